// ----- hdl/binary_to_ascii_number_formatter_core_macros.svh -----
// Assertion macros for the formatter top level.
`ifndef BINARY_TO_ASCII_NUMBER_FORMATTER_CORE_MACROS_SVH
`define BINARY_TO_ASCII_NUMBER_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BAFMT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("formatter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BAFMT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("formatter assertion failed");

`endif

// ----- hdl/bafmt_pkg.sv -----
// Types, constants and helper functions of the number formatter.
package bafmt_pkg;

  localparam int VAL_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = VAL_W / 4;
  localparam int BUF_LEN    = DEC_DIGITS + 1;
  localparam int PTR_W      = $clog2(BUF_LEN);
  localparam int CNT_W      = $clog2(VAL_W);

  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(BUF_LEN - 1);
  localparam logic [CNT_W-1:0] SHIFT_STEPS = CNT_W'(VAL_W - 1);

  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PERCENT  = 8'h25;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;

  typedef enum logic [2:0] {
    FN_LITERAL = 3'd0,
    FN_HEX     = 3'd1,
    FN_UDEC    = 3'd2,
    FN_SDEC    = 3'd3,
    FN_CHAR    = 3'd4,
    FN_PERCENT = 3'd5,
    FN_UNKNOWN = 3'd6
  } func_t;

  typedef struct packed {
    logic [2:0]       func;
    logic [VAL_W-1:0] value;
  } req_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } rsp_item_t;

  // Finished conversion handed from the digit chain to the character emitter.
  typedef struct packed {
    logic [2:0]                  kind;
    logic                        neg;
    logic [DEC_DIGITS-1:0][3:0]  digits;
    logic [VAL_W-1:0]            value;
  } conv_result_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] wide;
    wide = {4'b0000, nib};
    if (nib <= 4'd9) begin
      hex_char = CH_ZERO + wide;
    end else begin
      hex_char = CH_UPPER_A + wide - 8'd10;
    end
  endfunction

endpackage

// ----- hdl/bafmt_digit_cell.sv -----
// One BCD digit cell of the shift-and-correct conversion chain.
module bafmt_digit_cell (
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic       cin,
  output logic [3:0] digit,
  output logic       cout
);

  logic [4:0] dbl;

  // A valid digit doubled plus carry reaches ten exactly when it is five or more.
  assign dbl  = {digit, cin};
  assign cout = (digit >= 4'd5);

  always_ff @(posedge clk) begin
    if (load) begin
      digit <= {3'b000, cin};
    end else if (shift) begin
      if (dbl >= 5'd10) begin
        digit <= 4'(dbl - 5'd10);
      end else begin
        digit <= dbl[3:0];
      end
    end
  end

endmodule

// ----- hdl/bafmt_emitter.sv -----
// Character buffer and output register that streams one conversion's text.
module bafmt_emitter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     load,
  input  bafmt_pkg::conv_result_t  res,
  output logic                     free,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output bafmt_pkg::rsp_item_t     rsp
);

  logic                                  busy;
  logic [bafmt_pkg::PTR_W-1:0]           ptr;
  logic [bafmt_pkg::CHAR_W-1:0]          chars [bafmt_pkg::BUF_LEN];
  logic [bafmt_pkg::CHAR_W-1:0]          chars_next [bafmt_pkg::BUF_LEN];
  logic [bafmt_pkg::PTR_W-1:0]           start_next;
  logic [bafmt_pkg::PTR_W-1:0]           first;
  logic                                  at_last;

  assign at_last   = (ptr == bafmt_pkg::LAST_POS);
  assign free      = !busy || (!rsp_stall && at_last);
  assign rsp_valid = busy;
  assign rsp.out_char = chars[ptr];
  assign rsp.last     = at_last;

  // Lay out the text right-aligned so that every request ends at the last slot.
  always_comb begin
    first = bafmt_pkg::LAST_POS;
    for (int i = bafmt_pkg::DEC_DIGITS; i >= 1; i--) begin
      if (res.digits[bafmt_pkg::DEC_DIGITS - i] != 4'd0) begin
        first = bafmt_pkg::PTR_W'(i);
      end
    end
    for (int i = 0; i < bafmt_pkg::BUF_LEN; i++) begin
      chars_next[i] = bafmt_pkg::CH_ZERO;
    end
    start_next = bafmt_pkg::LAST_POS;
    unique case (res.kind) inside
      bafmt_pkg::FN_HEX: begin
        for (int h = 0; h < bafmt_pkg::HEX_DIGITS; h++) begin
          chars_next[bafmt_pkg::BUF_LEN - bafmt_pkg::HEX_DIGITS + h] =
            bafmt_pkg::hex_char(res.value[bafmt_pkg::VAL_W - 1 - 4 * h -: 4]);
        end
        start_next = bafmt_pkg::PTR_W'(bafmt_pkg::BUF_LEN - bafmt_pkg::HEX_DIGITS);
      end
      bafmt_pkg::FN_UDEC, bafmt_pkg::FN_SDEC: begin
        for (int i = 1; i <= bafmt_pkg::DEC_DIGITS; i++) begin
          chars_next[i] = bafmt_pkg::CH_ZERO
                          | {4'b0000, res.digits[bafmt_pkg::DEC_DIGITS - i]};
        end
        if (res.neg) begin
          chars_next[first - 1'b1] = bafmt_pkg::CH_MINUS;
          start_next = first - 1'b1;
        end else begin
          start_next = first;
        end
      end
      bafmt_pkg::FN_LITERAL, bafmt_pkg::FN_CHAR: begin
        chars_next[bafmt_pkg::LAST_POS] = res.value[bafmt_pkg::CHAR_W-1:0];
      end
      bafmt_pkg::FN_PERCENT: begin
        chars_next[bafmt_pkg::LAST_POS] = bafmt_pkg::CH_PERCENT;
      end
      default: begin
        chars_next[bafmt_pkg::LAST_POS] = bafmt_pkg::CH_QUESTION;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ptr  <= bafmt_pkg::LAST_POS;
    end else if (load) begin
      busy <= 1'b1;
      ptr  <= start_next;
    end else if (busy && !rsp_stall) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chars <= chars_next;
    end
  end

endmodule

// ----- hdl/binary_to_ascii_number_formatter_core.sv -----
// Top level of the binary-to-ASCII number formatter.
//
// Each request item on the req channel carries a conversion kind (func) and a
// 32-bit argument. The block answers on the rsp channel with one item per
// printed character, in printing order, and marks the final character of the
// request with last. Both channels use valid and stall; an item moves on a
// rising edge where valid is high and stall is low.
// Decimal kinds run a bit-serial shift-and-correct pass through a chain of ten
// BCD digit cells, one argument bit per cycle: the load cycle takes the first
// bit and each shift step the next, and once all argument bits are in, the
// digits go to the emitter as soon as it is free. Other kinds skip the shift
// steps and go from the converter registers to the emitter when it is free. A
// request passes the converter registers and then the emitter's character
// buffer before its first character appears on rsp. The converter accepts the
// next request on the same edge that it hands the finished one to the emitter,
// so conversion of one request overlaps the streaming of the previous one; the
// pace is set by the slower of the two. A stall on rsp holds the current
// character. req_stall is high while the converter holds a request that it is
// not handing on, including a finished one that waits for the emitter to free
// up. Reset empties both stages; no request is in flight after.
`include "binary_to_ascii_number_formatter_core_macros.svh"

module binary_to_ascii_number_formatter_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  bafmt_pkg::req_item_t  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output bafmt_pkg::rsp_item_t  rsp
);

  // Converter stage registers.
  logic                              busy;
  logic [bafmt_pkg::CNT_W-1:0]       cnt;
  logic [bafmt_pkg::VAL_W-1:0]       shreg;
  logic [2:0]                        kind;
  logic                              neg;

  logic                              load;
  logic                              shift;
  logic                              done;
  logic                              handoff;
  logic                              em_free;
  logic                              req_dec;
  logic                              req_neg;
  logic [bafmt_pkg::VAL_W-1:0]       mag;
  logic [bafmt_pkg::DEC_DIGITS-1:0]  cin;
  logic [bafmt_pkg::DEC_DIGITS-1:0]  cout;
  logic [bafmt_pkg::DEC_DIGITS-1:0][3:0] digits;
  logic                              bcd_ok;
  bafmt_pkg::conv_result_t           res;

  assign req_dec = (req.func == bafmt_pkg::FN_UDEC) || (req.func == bafmt_pkg::FN_SDEC);
  assign req_neg = (req.func == bafmt_pkg::FN_SDEC) && req.value[bafmt_pkg::VAL_W-1];
  // Signed requests convert the two's-complement magnitude.
  assign mag     = req_neg ? (~req.value + 1'b1) : req.value;

  assign load      = req_valid && !req_stall;
  assign shift     = busy && (cnt != '0);
  assign done      = busy && (cnt == '0);
  assign handoff   = done && em_free;
  assign req_stall = busy && !handoff;

  // The bit entering the least significant cell is the next argument bit; on
  // the load cycle the upper cells start from zero.
  always_comb begin
    cin[0] = load ? mag[bafmt_pkg::VAL_W-1] : shreg[bafmt_pkg::VAL_W-1];
    for (int d = 1; d < bafmt_pkg::DEC_DIGITS; d++) begin
      cin[d] = load ? 1'b0 : cout[d-1];
    end
    bcd_ok = 1'b1;
    for (int d = 0; d < bafmt_pkg::DEC_DIGITS; d++) begin
      if (digits[d] > 4'd9) begin
        bcd_ok = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < bafmt_pkg::DEC_DIGITS; g++) begin : g_cell
    bafmt_digit_cell u_cell (
      .clk   (clk),
      .load  (load),
      .shift (shift),
      .cin   (cin[g]),
      .digit (digits[g]),
      .cout  (cout[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= req_dec ? bafmt_pkg::SHIFT_STEPS : '0;
    end else if (handoff) begin
      busy <= 1'b0;
    end else if (shift) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind  <= req.func;
      neg   <= req_neg;
      shreg <= req_dec ? (mag << 1) : req.value;
    end else if (shift) begin
      shreg <= shreg << 1;
    end
  end

  assign res.kind   = kind;
  assign res.neg    = neg;
  assign res.digits = digits;
  assign res.value  = shreg;

  bafmt_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (handoff),
    .res       (res),
    .free      (em_free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // A decimal request cannot be finished on the cycle after it is taken.
  `BAFMT_ASSERT_NEXT(a_dec_not_early, clk, rst, load && req_dec, !handoff)
  // The digit cells hold valid BCD while a decimal conversion is in flight.
  `BAFMT_ASSERT_IMPL(a_cells_bcd, clk, rst,
    busy && ((kind == bafmt_pkg::FN_UDEC) || (kind == bafmt_pkg::FN_SDEC)), bcd_ok)
  // After the final character leaves with nothing handed over, rsp goes quiet.
  `BAFMT_ASSERT_NEXT(a_quiet_after_last, clk, rst,
    rsp_valid && !rsp_stall && rsp.last && !handoff, !rsp_valid)

endmodule

// ----- tb/sv/tb_binary_to_ascii_number_formatter_core.sv -----
// Self-checking testbench for the binary-to-ASCII number formatter core.
`timescale 1ns / 100ps

module tb_binary_to_ascii_number_formatter_core;

  // Kind 7 has no enum member. The block must answer it as an unknown kind.
  localparam logic [2:0] FN_RESERVED = 3'd7;
  localparam int RANDOM_REQS = 360;
  localparam int DRAIN_CYCLES = 40;
  localparam int STEADY_FIRST = 150;
  localparam int STEADY_END = 230;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  bafmt_pkg::req_item_t req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  bafmt_pkg::rsp_item_t rsp;

  bafmt_pkg::req_item_t pending_reqs[$];
  bafmt_pkg::rsp_item_t expected_chars[$];
  bafmt_pkg::rsp_item_t next_char;
  int        total_reqs = 0;
  int        reqs_taken = 0;
  int        chars_checked = 0;
  int        mismatch_count = 0;
  int        kind_taken[8];
  logic      steady;

  binary_to_ascii_number_formatter_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Neither side idles while this window of requests is being taken, so the
  // block also sees back-to-back requests and an output that never stalls.
  assign steady = (reqs_taken >= STEADY_FIRST) && (reqs_taken < STEADY_END);

  // Appends one character, not yet marked last, to the expected stream.
  function automatic void queue_char(input logic [7:0] c);
    expected_chars.push_back('{out_char: c, last: 1'b0});
  endfunction

  // Decimal text of an unsigned value: shift the value MSB first into ten BCD
  // cells, each cell doubling and taking the carry from the cell below, then
  // print from the top cell with leading zeros dropped.
  function automatic void queue_decimal(input logic [31:0] v);
    logic [3:0] cells[10];
    logic       carry;
    logic [4:0] doubled;
    logic       leading;
    leading = 1'b1;
    for (int d = 0; d < 10; d++) begin
      cells[d] = 4'd0;
    end
    for (int s = 0; s < 32; s++) begin
      carry = v[31];
      v = v << 1;
      for (int d = 0; d < 10; d++) begin
        doubled = {cells[d], carry};
        if (doubled >= 5'd10) begin
          carry = 1'b1;
          doubled = doubled - 5'd10;
        end else begin
          carry = 1'b0;
        end
        cells[d] = doubled[3:0];
      end
    end
    for (int d = 9; d >= 0; d--) begin
      if (cells[d] != 4'd0 || !leading) begin
        queue_char(bafmt_pkg::CH_ZERO + {4'b0000, cells[d]});
        leading = 1'b0;
      end
    end
    // A zero value still prints one digit.
    if (leading) begin
      queue_char(bafmt_pkg::CH_ZERO);
    end
  endfunction

  // Works out every character that one accepted request must produce.
  function automatic void predict_chars(input bafmt_pkg::req_item_t r);
    logic [3:0]           nib;
    bafmt_pkg::rsp_item_t tail;
    case (r.func)
      bafmt_pkg::FN_LITERAL, bafmt_pkg::FN_CHAR: begin
        queue_char(r.value[7:0]);
      end
      bafmt_pkg::FN_HEX: begin
        for (int i = 7; i >= 0; i--) begin
          nib = r.value[i*4 +: 4];
          if (nib <= 4'd9) begin
            queue_char(bafmt_pkg::CH_ZERO + {4'b0000, nib});
          end else begin
            queue_char(bafmt_pkg::CH_UPPER_A + {4'b0000, nib} - 8'd10);
          end
        end
      end
      bafmt_pkg::FN_UDEC: begin
        queue_decimal(r.value);
      end
      bafmt_pkg::FN_SDEC: begin
        if (r.value[31]) begin
          queue_char(bafmt_pkg::CH_MINUS);
          queue_decimal(~r.value + 32'd1);
        end else begin
          queue_decimal(r.value);
        end
      end
      bafmt_pkg::FN_PERCENT: begin
        queue_char(bafmt_pkg::CH_PERCENT);
      end
      default: begin
        queue_char(bafmt_pkg::CH_QUESTION);
      end
    endcase
    tail = expected_chars.pop_back();
    tail.last = 1'b1;
    expected_chars.push_back(tail);
  endfunction

  // Request driver: presents the next pending item, or idles at random. A
  // stalled item is held unchanged until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_chars(req);
        kind_taken[req.func]++;
        reqs_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Character monitor: every taken character is compared with the oldest
  // expected one. The stall for the next cycle is chosen at random, except in the steady window where it stays low.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: no character expected, got %h (last %b)", rsp.out_char, rsp.last);
          mismatch_count++;
        end else begin
          next_char = expected_chars.pop_front();
          if (rsp.out_char !== next_char.out_char) begin
            $error("out_char: expected %h, got %h", next_char.out_char, rsp.out_char);
            mismatch_count++;
          end
          if (rsp.last !== next_char.last) begin
            $error("last: expected %b, got %b", next_char.last, rsp.last);
            mismatch_count++;
          end
        end
        chars_checked++;
      end
      rsp_stall <= !steady && ($urandom_range(99) < 36);
    end
  end

  initial begin
    logic [2:0]  f;
    logic [31:0] v;
    int          pick;

    // Directed requests: field extremes, every kind, and the special cases
    // of zero, the most negative value, minus one and the reserved kind.
    pending_reqs.push_back('{func: bafmt_pkg::FN_LITERAL, value: 32'h0000_0000});
    pending_reqs.push_back('{func: bafmt_pkg::FN_LITERAL, value: 32'hFFFF_FFFF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_CHAR,    value: 32'hA5C3_7E41});
    pending_reqs.push_back('{func: bafmt_pkg::FN_CHAR,    value: 32'h0000_00FF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_HEX,     value: 32'h0000_0000});
    pending_reqs.push_back('{func: bafmt_pkg::FN_HEX,     value: 32'hFFFF_FFFF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_HEX,     value: 32'h0123_ABCD});
    pending_reqs.push_back('{func: bafmt_pkg::FN_HEX,     value: 32'h89EF_4567});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UDEC,    value: 32'd0});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UDEC,    value: 32'd9});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UDEC,    value: 32'd10});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UDEC,    value: 32'd1000000000});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UDEC,    value: 32'hFFFF_FFFF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_SDEC,    value: 32'd0});
    pending_reqs.push_back('{func: bafmt_pkg::FN_SDEC,    value: 32'h8000_0000});
    pending_reqs.push_back('{func: bafmt_pkg::FN_SDEC,    value: 32'hFFFF_FFFF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_SDEC,    value: 32'h7FFF_FFFF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_SDEC,    value: 32'hFFFF_FFF6});
    pending_reqs.push_back('{func: bafmt_pkg::FN_PERCENT, value: 32'hDEAD_BEEF});
    pending_reqs.push_back('{func: bafmt_pkg::FN_UNKNOWN, value: 32'h1234_5678});
    pending_reqs.push_back('{func: FN_RESERVED, value: 32'hFFFF_FFFF});

    // Random requests, weighted toward the decimal kinds, with values spread
    // over all magnitudes and around powers of ten.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(99);
      if (pick < 10) f = bafmt_pkg::FN_LITERAL;
      else if (pick < 25) f = bafmt_pkg::FN_HEX;
      else if (pick < 50) f = bafmt_pkg::FN_UDEC;
      else if (pick < 80) f = bafmt_pkg::FN_SDEC;
      else if (pick < 88) f = bafmt_pkg::FN_CHAR;
      else if (pick < 93) f = bafmt_pkg::FN_PERCENT;
      else if (pick < 97) f = bafmt_pkg::FN_UNKNOWN;
      else f = FN_RESERVED;
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $urandom >> $urandom_range(31);
        2: begin
          v = 32'd1;
          repeat ($urandom_range(9)) v = v * 32'd10;
          v = v - $urandom_range(1);
        end
        default: v = -($urandom >> $urandom_range(31));
      endcase
      pending_reqs.push_back('{func: f, value: v});
    end
    total_reqs = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (reqs_taken < total_reqs) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    // Any character that shows up now is an extra one and fails in the monitor.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d characters from %0d requests.", chars_checked, reqs_taken);
    $display("Requests per kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_taken[0], kind_taken[1], kind_taken[2], kind_taken[3],
             kind_taken[4], kind_taken[5], kind_taken[6], kind_taken[7]);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #(12 * 300000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bafmt_pkg.sv
hdl/bafmt_digit_cell.sv
hdl/bafmt_emitter.sv
hdl/binary_to_ascii_number_formatter_core.sv
tb/sv/tb_binary_to_ascii_number_formatter_core.sv
